[sv/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/bdp_pkg.sv]
// Shared types, constants and helpers for the beeper duty to PCM converter.
package bdp_pkg;

  localparam int CNT_W = 32;
  localparam int CLK_W = 64;
  localparam int OUT_W = 14;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_st_t;

  // Clock difference modulo 2^64, saturated to 32 bits.
  function automatic logic [CNT_W-1:0] span32(input logic [CLK_W-1:0] now_v,
                                             input logic [CLK_W-1:0] then_v);
    logic [CLK_W-1:0] d;
    d = now_v - then_v;
    return (d[CLK_W-1:CNT_W] != '0) ? {CNT_W{1'b1}} : d[CNT_W-1:0];
  endfunction

endpackage

[sv/bdp_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module bdp_div #(
  parameter int QW = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bdp_pkg::div_ctl_t                 ctl,
  input  logic [bdp_pkg::CNT_W+QW-1:0]      dividend,
  input  logic [bdp_pkg::CNT_W-1:0]         divisor,
  output bdp_pkg::div_st_t                  st,
  output logic [QW-1:0]                     quotient
);
  import bdp_pkg::*;

  localparam int CW = $clog2(QW + 1);

  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] dvs_r;
  logic [QW-1:0]    low_r;
  logic [QW-1:0]    quot_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             qbit;

  // Caller guarantees the upper dividend bits are below the divisor.
  always_comb begin
    trial = {rem_r, low_r[QW-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (ctl.start) begin
      cnt_r  <= CW'(QW);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CW'(1);
      done_r <= (cnt_r == CW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r  <= dividend[CNT_W+QW-1:QW];
      low_r  <= dividend[QW-1:0];
      dvs_r  <= divisor;
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      low_r  <= QW'({low_r, 1'b0});
      quot_r <= QW'({quot_r, qbit});
    end
  end

  assign st.busy  = (cnt_r != '0);
  assign st.done  = done_r;
  assign quotient = quot_r;

endmodule

[sv/beeper_duty_to_pcm_sample.sv]
// Beeper duty-cycle to PCM converter: sequencer, state and config registers.
// Level event: accounted in ST_ACC after ST_SPAN, then back to ST_IDLE for the next accept.
// Sample request: states SPAN, ACC, MUL, DIV and FIN, then the output register sets out_valid,
// with in_ready back in that same cycle; the radix-2 divider takes one quotient bit per cycle.
// Not ready while an item is in work or a finished sample waits for the output register.
// Synchronous active-low reset clears level, on-time, clock marks, config, state and out_valid.
`include "assert_macros.svh"
module beeper_duty_to_pcm_sample #(
  parameter int AMP_FULL_SCALE = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [bdp_pkg::CLK_W-1:0]     in_clock_now,
  input  logic                          in_line_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [bdp_pkg::OUT_W-1:0] out_sample_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bdp_pkg::*;

  localparam int AW = $clog2(AMP_FULL_SCALE + 1);
  localparam int PW = CNT_W + AW;
  localparam int MW = (AW > OUT_W) ? AW : OUT_W;
  localparam logic [AW-1:0] AMP_V = AW'(AMP_FULL_SCALE);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SPAN = 6'b000010,
    ST_ACC  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic             muted_r, inv_r;
  logic             level_r;
  logic [CNT_W-1:0] on_r;
  logic [CLK_W-1:0] last_r, win_r;
  logic [CLK_W-1:0] now_r;
  logic             act_r, lvl_in_r;
  logic [CNT_W-1:0] span_r, ticks_r;
  logic             zero_r, sat_r;
  logic [AW-1:0]    mag_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_r;

  div_ctl_t         div_ctl;
  div_st_t          div_st;
  logic [PW-1:0]    dividend;
  logic [AW-1:0]    quot;
  logic [CNT_W:0]   sum33;
  logic [MW-1:0]    mag_w;
  logic [OUT_W-1:0] mag_o;
  logic             in_acc, cfg_wr, out_load;

  assign in_acc   = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign prdata   = {31'b0, paddr[2] ? inv_r : muted_r};
  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  assign sum33    = {1'b0, on_r} + {1'b0, span_r};
  assign dividend = PW'(on_r) * PW'(AMP_V);
  assign div_ctl.start = (state_r == ST_MUL);

  always_comb begin
    mag_w = MW'(mag_r);
    mag_o = mag_w[OUT_W-1:0];
  end

  bdp_div #(.QW(AW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (dividend),
    .divisor  (ticks_r),
    .st       (div_st),
    .quotient (quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SPAN;
      ST_SPAN: state_nxt = ST_ACC;
      ST_ACC:  state_nxt = act_r ? ST_MUL : ST_IDLE;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (div_st.done) state_nxt = ST_FIN;
      ST_FIN:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      muted_r     <= 1'b0;
      inv_r       <= 1'b0;
      level_r     <= 1'b0;
      on_r        <= '0;
      last_r      <= '0;
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2]) inv_r   <= pwdata[0];
        else          muted_r <= pwdata[0];
      end
      if (state_r == ST_ACC) begin
        if (level_r) on_r <= sum33[CNT_W] ? {CNT_W{1'b1}} : sum33[CNT_W-1:0];
        last_r <= now_r;
        if (!act_r) level_r <= lvl_in_r;
      end
      // Window restarts once the product has been handed to the divider.
      if (state_r == ST_MUL) begin
        on_r  <= '0;
        win_r <= now_r;
      end
      if (out_load)                    out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r    <= in_clock_now;
      act_r    <= in_action;
      lvl_in_r <= in_line_level;
    end
    if (state_r == ST_SPAN) begin
      span_r  <= span32(now_r, last_r);
      ticks_r <= span32(now_r, win_r);
    end
    if (state_r == ST_MUL) begin
      zero_r <= (ticks_r == '0);
      // on_time >= ticks means the quotient reaches full scale.
      sat_r  <= (on_r >= ticks_r);
    end
    if (state_r == ST_DIV && div_st.done) begin
      priority if (zero_r) mag_r <= '0;
      else if (sat_r)      mag_r <= AMP_V;
      else                 mag_r <= quot;
    end
    if (out_load) begin
      priority if (muted_r) out_r <= '0;
      else if (inv_r)       out_r <= OUT_W'(0) - mag_o;
      else                  out_r <= mag_o;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_r;

  `ASSERT_IMPL(a_div_busy_in_div, clk, rst_n, div_st.busy, state_r == ST_DIV)
  `ASSERT_IMPL(a_div_done_in_div, clk, rst_n, div_st.done, state_r == ST_DIV)
  `ASSERT_IMPL(a_mag_bound, clk, rst_n, state_r == ST_FIN, mag_r <= AMP_V)
  `ASSERT_NEXT(a_level_no_sample, clk, rst_n, (state_r == ST_ACC) && !act_r,
               state_r == ST_IDLE)

endmodule
